### hdl/rlpd_pkg.sv
`default_nettype none
package rlpd_pkg;

   // operation codes carried in tuser
   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_CURVE_WRITE = 2'd1,
      OP_PACKED_LOAD = 2'd2,
      OP_SET_ALL     = 2'd3
   } op_type;

   localparam int LEVEL_W     = 8;
   localparam int FIELD_W     = 5;
   localparam int WORD_W      = 16;
   localparam int NUM_WORDS   = 4;
   localparam int GAMMA_BIT   = 15;
   localparam int COLORS      = 3;
   localparam int CURVE_DEPTH = 32;
   // curve store address: curve select on top of the entry index
   localparam int CURVE_ADDR_W = FIELD_W + 1;
   localparam int PIN_W       = 12;
   localparam logic [LEVEL_W-1:0] PHASE_TOP = 8'd254;

   // request tdata layout
   localparam int CW_LSB    = 0;
   localparam int RED_LSB   = NUM_WORDS * WORD_W;
   localparam int GREEN_LSB = RED_LSB + LEVEL_W;
   localparam int BLUE_LSB  = GREEN_LSB + LEVEL_W;
   localparam int SEL_LSB   = BLUE_LSB + LEVEL_W;
   localparam int IDX_LSB   = SEL_LSB + 1;
   localparam int VAL_LSB   = IDX_LSB + FIELD_W;
   localparam int REQ_USED_W = VAL_LSB + LEVEL_W;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout
   localparam int PHASE_LSB  = PIN_W;
   localparam int RSP_USED_W = PIN_W + LEVEL_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // item held between the input register and the dimmer core
   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } stage_type;

endpackage
`default_nettype wire

### hdl/rlpd_curve_mem.sv
`default_nettype none
module rlpd_curve_mem (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [rlpd_pkg::CURVE_ADDR_W-1:0]     wr_addr,
   input  wire logic [rlpd_pkg::LEVEL_W-1:0]          wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [rlpd_pkg::CURVE_ADDR_W-1:0]     rd_addr,
   output logic      [rlpd_pkg::LEVEL_W-1:0]          rd_data_ff
);

   // linear curve in the lower half, gamma curve in the upper half
   logic [rlpd_pkg::LEVEL_W-1:0] mem [2*rlpd_pkg::CURVE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/rlpd_core.sv
`default_nettype none
module rlpd_core #(
   parameter int NUM_LEDS = 4
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           s1_valid,
   input  wire rlpd_pkg::stage_type                            s1_item,
   input  wire logic [3*NUM_LEDS-1:0][rlpd_pkg::LEVEL_W-1:0]   curve_levels,
   output logic                                                s1_ready,
   output logic                                                rsp_tvalid,
   input  wire logic                                           rsp_tready,
   output logic      [rlpd_pkg::RSP_DATA_W-1:0]                rsp_tdata
);

   localparam int NUM_CH = 3 * NUM_LEDS;
   localparam int PIN_CH = (NUM_CH < rlpd_pkg::PIN_W) ? NUM_CH : rlpd_pkg::PIN_W;

   logic [NUM_CH-1:0][rlpd_pkg::LEVEL_W-1:0] levels_ff, levels_in;
   logic [rlpd_pkg::LEVEL_W-1:0]             phase_ff, phase_in;
   logic [rlpd_pkg::PIN_W-1:0]               pins_ff, pins_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [rlpd_pkg::RSP_DATA_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                                     advance;

   assign s1_ready = !rsp_valid_ff || rsp_tready;
   assign advance  = s1_valid && s1_ready;

   always_comb begin
      levels_in = levels_ff;
      phase_in  = phase_ff;
      pins_in   = pins_ff;
      case (s1_item.op)
         rlpd_pkg::OP_TICK: begin
            if (phase_ff == rlpd_pkg::PHASE_TOP) begin
               phase_in = '0;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
            // pin low (led on) while level is above the new phase
            pins_in = '0;
            for (int ch = 0; ch < PIN_CH; ch++) begin
               pins_in[ch] = !(levels_ff[ch] > phase_in);
            end
         end
         rlpd_pkg::OP_PACKED_LOAD: begin
            levels_in = curve_levels;
         end
         rlpd_pkg::OP_SET_ALL: begin
            for (int k = 0; k < NUM_LEDS; k++) begin
               levels_in[3*k]     = s1_item.red;
               levels_in[3*k + 1] = s1_item.green;
               levels_in[3*k + 2] = s1_item.blue;
            end
         end
         default: begin
            // curve writes were done at the input side
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[rlpd_pkg::PIN_W-1:0] = pins_in;
         rsp_data_in[rlpd_pkg::PHASE_LSB +: rlpd_pkg::LEVEL_W] = phase_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff    <= '0;
         phase_ff     <= '0;
         pins_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            levels_ff <= levels_in;
            phase_ff  <= phase_in;
            pins_ff   <= pins_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### hdl/rgb_led_pwm_dimmer_top.sv
// an accepted item passes the input register and then the result register, held longer while rsp_tready is low
// throughput: one item per cycle; input register, curve store read and result register
//    form a two-stage pipeline that stalls only when the result register is full
// reset (synchronous, active high): phase 0, all levels 0, all pins high (leds off),
//    both stages empty; the gamma and linear curves hold no defined value until written
`default_nettype none
module rgb_led_pwm_dimmer_top #(
   parameter int NUM_LEDS = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata from bit 0: color_word_0..3, red, green, blue, curve_select, curve_index,
   // curve_value, zero fill
   input  wire logic [rlpd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: op
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata from bit 0: led_pins_n, pwm_phase, zero fill
   output logic      [rlpd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int NUM_CH = 3 * NUM_LEDS;

   logic                                      req_accept;
   rlpd_pkg::op_type                          req_op;
   logic                                      curve_wr_en;
   logic                                      curve_rd_en;
   logic [rlpd_pkg::CURVE_ADDR_W-1:0]         curve_wr_addr;
   logic [rlpd_pkg::LEVEL_W-1:0]              curve_wr_data;
   logic [NUM_CH-1:0][rlpd_pkg::LEVEL_W-1:0]  curve_levels;

   logic                  s1_valid_ff, s1_valid_in;
   rlpd_pkg::stage_type   s1_item_ff, s1_item_in;
   logic                  s1_ready;

   // input stage takes a new item whenever it is empty or the held one moves on this cycle
   assign req_tready = !s1_valid_ff || s1_ready;
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = rlpd_pkg::op_type'(req_tuser);

   // curve writes land at acceptance, so an item right behind sees them
   assign curve_wr_en   = req_accept && (req_op == rlpd_pkg::OP_CURVE_WRITE);
   assign curve_rd_en   = req_accept && (req_op == rlpd_pkg::OP_PACKED_LOAD);
   assign curve_wr_addr = {req_tdata[rlpd_pkg::SEL_LSB],
                           req_tdata[rlpd_pkg::IDX_LSB +: rlpd_pkg::FIELD_W]};
   assign curve_wr_data = req_tdata[rlpd_pkg::VAL_LSB +: rlpd_pkg::LEVEL_W];

   // one copy of the curve store per channel, all written alike, each read once
   for (genvar k = 0; k < NUM_LEDS; k++) begin : g_led
      // led k takes its packed word from color word k mod 4
      localparam int WORD_LSB = rlpd_pkg::CW_LSB + (k % rlpd_pkg::NUM_WORDS) * rlpd_pkg::WORD_W;
      logic [rlpd_pkg::WORD_W-1:0] word;
      assign word = req_tdata[WORD_LSB +: rlpd_pkg::WORD_W];
      for (genvar c = 0; c < rlpd_pkg::COLORS; c++) begin : g_color
         logic [rlpd_pkg::CURVE_ADDR_W-1:0] rd_addr;
         // gamma bit picks the upper half of the store
         assign rd_addr = {word[rlpd_pkg::GAMMA_BIT],
                           word[c*rlpd_pkg::FIELD_W +: rlpd_pkg::FIELD_W]};
         rlpd_curve_mem u_curve (
            .clock      (clock),
            .wr_en      (curve_wr_en),
            .wr_addr    (curve_wr_addr),
            .wr_data    (curve_wr_data),
            .rd_en      (curve_rd_en),
            .rd_addr    (rd_addr),
            .rd_data_ff (curve_levels[3*k + c])
         );
      end
   end

   // input register: op and the set-all triple
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_valid_in      = 1'b1;
         s1_item_in.op    = req_op;
         s1_item_in.red   = req_tdata[rlpd_pkg::RED_LSB   +: rlpd_pkg::LEVEL_W];
         s1_item_in.green = req_tdata[rlpd_pkg::GREEN_LSB +: rlpd_pkg::LEVEL_W];
         s1_item_in.blue  = req_tdata[rlpd_pkg::BLUE_LSB  +: rlpd_pkg::LEVEL_W];
      end else if (s1_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   // phase counter, channel levels, pin latch and result register
   rlpd_core #(
      .NUM_LEDS (NUM_LEDS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_valid_ff),
      .s1_item      (s1_item_ff),
      .curve_levels (curve_levels),
      .s1_ready     (s1_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
`default_nettype wire

### hdl/rlpd_checker.sv
`default_nettype none
module rlpd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [rlpd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // phase counter wraps after its top value
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[rlpd_pkg::PHASE_LSB +: rlpd_pkg::LEVEL_W] <= rlpd_pkg::PHASE_TOP)
      else $error("phase out of range");

   // an accepted item passes the input register, then the result register is valid
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted item left no result");

   // input backpressure only when the result side is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

endmodule

bind rgb_led_pwm_dimmer_top rlpd_checker u_rlpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

### tb/rgb_led_pwm_dimmer_top_test.sv
module rgb_led_pwm_dimmer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_LEDS        = 4;
   localparam int NUM_CH          = rlpd_pkg::COLORS * NUM_LEDS;
   // quiet cycles allowed before the run is declared hung; well above the long hold-off
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RSP_HOLD_CYCLES = 150;
   localparam int PRESSURE_ITEMS  = 40;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int DRAIN_CYCLES    = 8;

   // one request item, fields as they travel in tdata and tuser
   typedef struct packed {
      rlpd_pkg::op_type             op;
      logic [63:0]                  words;   // color_word_3 .. color_word_0
      logic [rlpd_pkg::LEVEL_W-1:0] red;
      logic [rlpd_pkg::LEVEL_W-1:0] green;
      logic [rlpd_pkg::LEVEL_W-1:0] blue;
      logic                         sel;
      logic [rlpd_pkg::FIELD_W-1:0] idx;
      logic [rlpd_pkg::LEVEL_W-1:0] val;
   } dimmer_req_type;

   // one result item
   typedef struct packed {
      logic [rlpd_pkg::PIN_W-1:0]   pins;
      logic [rlpd_pkg::LEVEL_W-1:0] phase;
   } pin_phase_type;

   // directed stimulus row; typed result only where it is obvious
   typedef struct packed {
      dimmer_req_type req;
      logic           typed;
      pin_phase_type  result;
   } dir_row_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // request side, driven on the falling edge
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [rlpd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                      req_tuser  = 2'd0;

   // result side
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rlpd_pkg::RSP_DATA_W-1:0] rsp_tdata;

   rgb_led_pwm_dimmer_top #(
      .NUM_LEDS(NUM_LEDS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------
   // predictor state: phase counter, channel levels, both curves, pin latch
   // ------------------------------------------------------------------
   logic [rlpd_pkg::LEVEL_W-1:0] mdl_phase;
   logic [rlpd_pkg::LEVEL_W-1:0] mdl_level [NUM_CH];
   logic [rlpd_pkg::LEVEL_W-1:0] mdl_linear [rlpd_pkg::CURVE_DEPTH];
   logic [rlpd_pkg::LEVEL_W-1:0] mdl_gamma [rlpd_pkg::CURVE_DEPTH];
   logic [rlpd_pkg::PIN_W-1:0]   mdl_pins;

   // curve entries written so far; packed loads only index these
   bit lin_written [rlpd_pkg::CURVE_DEPTH];
   bit gam_written [rlpd_pkg::CURVE_DEPTH];
   logic [rlpd_pkg::FIELD_W-1:0] lin_idx_q [$];
   logic [rlpd_pkg::FIELD_W-1:0] gam_idx_q [$];

   // expected results in item order
   pin_phase_type pending_rsp_q [$];
   dir_row_type   dir_rows [$];

   // run bookkeeping
   int tick_cnt     = 0;
   int write_cnt    = 0;
   int load_cnt     = 0;
   int setall_cnt   = 0;
   int wrap_cnt     = 0;
   int checked_cnt  = 0;
   int mismatch_cnt = 0;

   // knobs for the sender and the receiver
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asked    = 0;

   // advance the predictor by one accepted item and return its result
   function automatic pin_phase_type dimmer_step(input dimmer_req_type r);
      pin_phase_type                res;
      logic [rlpd_pkg::WORD_W-1:0]  w;
      logic [rlpd_pkg::FIELD_W-1:0] f;
      case (r.op)
         rlpd_pkg::OP_TICK: begin
            if (mdl_phase == rlpd_pkg::PHASE_TOP) begin
               mdl_phase = '0;
               wrap_cnt++;
            end else begin
               mdl_phase = mdl_phase + 8'd1;
            end
            // pin low (led on) while level is above the new phase
            for (int ch = 0; ch < rlpd_pkg::PIN_W; ch++)
               mdl_pins[ch] = !(mdl_level[ch] > mdl_phase);
         end
         rlpd_pkg::OP_CURVE_WRITE: begin
            if (r.sel) begin
               mdl_gamma[r.idx] = r.val;
               if (!gam_written[r.idx]) begin
                  gam_written[r.idx] = 1'b1;
                  gam_idx_q.push_back(r.idx);
               end
            end else begin
               mdl_linear[r.idx] = r.val;
               if (!lin_written[r.idx]) begin
                  lin_written[r.idx] = 1'b1;
                  lin_idx_q.push_back(r.idx);
               end
            end
         end
         rlpd_pkg::OP_PACKED_LOAD: begin
            for (int k = 0; k < NUM_LEDS; k++) begin
               w = r.words[rlpd_pkg::WORD_W*(k % rlpd_pkg::NUM_WORDS) +: rlpd_pkg::WORD_W];
               for (int c = 0; c < rlpd_pkg::COLORS; c++) begin
                  f = w[rlpd_pkg::FIELD_W*c +: rlpd_pkg::FIELD_W];
                  mdl_level[rlpd_pkg::COLORS*k + c] =
                     w[rlpd_pkg::GAMMA_BIT] ? mdl_gamma[f] : mdl_linear[f];
               end
            end
         end
         default: begin
            for (int k = 0; k < NUM_LEDS; k++) begin
               mdl_level[rlpd_pkg::COLORS*k]     = r.red;
               mdl_level[rlpd_pkg::COLORS*k + 1] = r.green;
               mdl_level[rlpd_pkg::COLORS*k + 2] = r.blue;
            end
         end
      endcase
      res.pins  = mdl_pins;
      res.phase = mdl_phase;
      return res;
   endfunction

   function automatic logic [rlpd_pkg::REQ_DATA_W-1:0] pack_req(input dimmer_req_type r);
      logic [rlpd_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[rlpd_pkg::CW_LSB +: rlpd_pkg::NUM_WORDS*rlpd_pkg::WORD_W] = r.words;
      d[rlpd_pkg::RED_LSB +: rlpd_pkg::LEVEL_W]   = r.red;
      d[rlpd_pkg::GREEN_LSB +: rlpd_pkg::LEVEL_W] = r.green;
      d[rlpd_pkg::BLUE_LSB +: rlpd_pkg::LEVEL_W]  = r.blue;
      d[rlpd_pkg::SEL_LSB]                        = r.sel;
      d[rlpd_pkg::IDX_LSB +: rlpd_pkg::FIELD_W]   = r.idx;
      d[rlpd_pkg::VAL_LSB +: rlpd_pkg::LEVEL_W]   = r.val;
      return d;
   endfunction

   // random item; packed loads only point at curve entries already written
   function automatic dimmer_req_type rand_req();
      dimmer_req_type r;
      int             pick;
      logic           g;
      r.words = {$urandom, $urandom};
      r.red   = 8'($urandom_range(255));
      r.green = 8'($urandom_range(255));
      r.blue  = 8'($urandom_range(255));
      r.sel   = 1'($urandom_range(1));
      r.idx   = 5'($urandom_range(rlpd_pkg::CURVE_DEPTH-1));
      r.val   = 8'($urandom_range(255));
      pick    = $urandom_range(99);
      if (pick < 50)
         r.op = rlpd_pkg::OP_TICK;
      else if (pick < 64)
         r.op = rlpd_pkg::OP_CURVE_WRITE;
      else if (pick < 86)
         r.op = rlpd_pkg::OP_PACKED_LOAD;
      else
         r.op = rlpd_pkg::OP_SET_ALL;
      if (r.op == rlpd_pkg::OP_PACKED_LOAD) begin
         if (lin_idx_q.size() == 0 && gam_idx_q.size() == 0) begin
            r.op = rlpd_pkg::OP_CURVE_WRITE;
         end else begin
            for (int k = 0; k < rlpd_pkg::NUM_WORDS; k++) begin
               g = r.words[rlpd_pkg::WORD_W*k + rlpd_pkg::GAMMA_BIT];
               if (g ? gam_idx_q.size() == 0 : lin_idx_q.size() == 0)
                  g = ~g;
               r.words[rlpd_pkg::WORD_W*k + rlpd_pkg::GAMMA_BIT] = g;
               for (int c = 0; c < rlpd_pkg::COLORS; c++)
                  r.words[rlpd_pkg::WORD_W*k + rlpd_pkg::FIELD_W*c +: rlpd_pkg::FIELD_W] = g ?
                     gam_idx_q[$urandom_range(gam_idx_q.size()-1)] :
                     lin_idx_q[$urandom_range(lin_idx_q.size()-1)];
            end
         end
      end
      return r;
   endfunction

   function automatic dir_row_type dir_row(input rlpd_pkg::op_type op,
                                           input logic [63:0] words,
                                           input logic [7:0] red, input logic [7:0] green,
                                           input logic [7:0] blue, input logic sel,
                                           input logic [4:0] idx, input logic [7:0] val,
                                           input logic typed, input logic [11:0] pins,
                                           input logic [7:0] phase);
      dir_row_type row;
      row.req.op     = op;
      row.req.words  = words;
      row.req.red    = red;
      row.req.green  = green;
      row.req.blue   = blue;
      row.req.sel    = sel;
      row.req.idx    = idx;
      row.req.val    = val;
      row.typed      = typed;
      row.result     = {pins, phase};
      return row;
   endfunction

   // offer one item, wait for it to be taken, queue what it should produce;
   // entered and left at a falling edge
   task automatic send_req(input dimmer_req_type r, input logic typed,
                           input pin_phase_type typed_res);
      pin_phase_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_req(r);
      req_tuser  <= r.op;
      do @(posedge clock); while (!req_tready);
      res = dimmer_step(r);
      pending_rsp_q.push_back(typed ? typed_res : res);
      case (r.op)
         rlpd_pkg::OP_TICK:        tick_cnt++;
         rlpd_pkg::OP_CURVE_WRITE: write_cnt++;
         rlpd_pkg::OP_PACKED_LOAD: load_cnt++;
         default:                  setall_cnt++;
      endcase
      @(negedge clock);
   endtask

   // sender goes quiet until every expected result has come back
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // result checker: sampled on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      pin_phase_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result item with no expectation pending: tdata %h", rsp_tdata);
            mismatch_cnt++;
         end else begin
            want = pending_rsp_q.pop_front();
            checked_cnt++;
            if (rsp_tdata[rlpd_pkg::PIN_W-1:0] !== want.pins) begin
               $error("led_pins_n: expected %h, got %h", want.pins,
                      rsp_tdata[rlpd_pkg::PIN_W-1:0]);
               mismatch_cnt++;
            end
            if (rsp_tdata[rlpd_pkg::PHASE_LSB +: rlpd_pkg::LEVEL_W] !== want.phase) begin
               $error("pwm_phase: expected %0d, got %0d", want.phase,
                      rsp_tdata[rlpd_pkg::PHASE_LSB +: rlpd_pkg::LEVEL_W]);
               mismatch_cnt++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: ends the run when nothing moves on either side for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles, %0d results pending",
               WATCHDOG_LIMIT, pending_rsp_q.size());
      $display("rgb_led_pwm_dimmer_top_test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      int send_idle_by_phase [4];
      int rsp_stall_by_phase [4];
      send_idle_by_phase = '{0, 74, 0, 9};
      rsp_stall_by_phase = '{0, 0, 74, 9};

      // predictor reset state: phase 0, levels 0, all pins high
      mdl_phase = '0;
      mdl_pins  = '1;
      foreach (mdl_level[i]) mdl_level[i] = '0;
      foreach (mdl_linear[i]) begin
         mdl_linear[i]  = '0;
         mdl_gamma[i]   = '0;
         lin_written[i] = 1'b0;
         gam_written[i] = 1'b0;
      end

      // directed rows: op, words {w3,w2,w1,w0}, r, g, b, sel, idx, val, typed, pins, phase
      // first tick after reset: all levels zero so every led stays off
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b1, 12'hFFF, 8'd1));
      // set all full on; pins do not move until the next tick
      dir_rows.push_back(dir_row(rlpd_pkg::OP_SET_ALL, 64'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 5'd0,
                                 8'h00, 1'b1, 12'hFFF, 8'd1));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1, 5'd31,
                                 8'hFF, 1'b1, 12'h000, 8'd2));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_SET_ALL, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b1, 12'h000, 8'd2));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b1, 12'hFFF, 8'd3));
      // curve extremes: first and last entry of both curves, min and max values, plus one middle entry of each
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0,
                                 5'd0, 8'h00, 1'b1, 12'hFFF, 8'd3));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0,
                                 5'd31, 8'hFF, 1'b1, 12'hFFF, 8'd3));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1,
                                 5'd0, 8'hFF, 1'b1, 12'hFFF, 8'd3));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1,
                                 5'd31, 8'h00, 1'b1, 12'hFFF, 8'd3));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0,
                                 5'd10, 8'hA5, 1'b1, 12'hFFF, 8'd3));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_CURVE_WRITE, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1,
                                 5'd21, 8'h5A, 1'b1, 12'hFFF, 8'd3));
      // packed load: led1 linear 0, led2 linear 255, led3 gamma 255, led4 gamma 0
      dir_rows.push_back(dir_row(rlpd_pkg::OP_PACKED_LOAD, 64'hFFFF_8000_7FFF_0000, 8'h00,
                                 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 1'b1, 12'hFFF, 8'd3));
      // next tick shows leds 2 and 3 on
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b1, 12'hE07, 8'd4));
      // mixed fields and curves per word
      dir_rows.push_back(dir_row(rlpd_pkg::OP_PACKED_LOAD, 64'hD6A0_7D5F_FC15_03EA, 8'h00,
                                 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 1'b0, 12'h0, 8'd0));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b0, 12'h0, 8'd0));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_SET_ALL, 64'h0, 8'h80, 8'h01, 8'hFE, 1'b0, 5'd0,
                                 8'h00, 1'b0, 12'h0, 8'd0));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b0, 12'h0, 8'd0));
      dir_rows.push_back(dir_row(rlpd_pkg::OP_TICK, 64'h0, 8'h00, 8'h00, 8'h00, 1'b0, 5'd0,
                                 8'h00, 1'b0, 12'h0, 8'd0));

      // synchronous reset, released on a falling edge
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].result);
      pause_until_drained();

      // random phases with different idle and stall mixes
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_idle_by_phase[p];
         rsp_stall_pct = rsp_stall_by_phase[p];
         repeat (ITEMS_PER_PHASE) send_req(rand_req(), 1'b0, '0);
         pause_until_drained();

         // after the free-running phase: long receiver hold-off while items keep coming
         if (p == 0) begin
            hold_asked++;
            repeat (PRESSURE_ITEMS) send_req(rand_req(), 1'b0, '0);
            pause_until_drained();
         end
      end

      // let any stray result show up before the verdict
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_rsp_q.size() != 0)
         $error("%0d expected results never arrived", pending_rsp_q.size());

      $display("items: %0d ticks, %0d curve writes, %0d packed loads, %0d set-all",
               tick_cnt, write_cnt, load_cnt, setall_cnt);
      $display("results checked: %0d, phase wraps: %0d, curve entries used: %0d linear %0d gamma",
               checked_cnt, wrap_cnt, lin_idx_q.size(), gam_idx_q.size());
      if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
         $display("rgb_led_pwm_dimmer_top_test passed");
      end else begin
         $display("rgb_led_pwm_dimmer_top_test failed");
      end
      $finish;
   end

endmodule
